FILE: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types, register codes and helpers for the cache lookup block
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W   = 32;
  localparam int TAG_W    = ADDR_W - 2;
  localparam int TICK_W   = 64;
  localparam int UCNT_W   = 32;
  localparam int LFSR_W   = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // register indexes
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_WAYS   = 2'd1;
  localparam logic [1:0] REG_INDEX  = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  // replacement policy codes
  localparam logic [2:0] POL_RR  = 3'd0;
  localparam logic [2:0] POL_RND = 3'd1;
  localparam logic [2:0] POL_LRU = 3'd2;
  localparam logic [2:0] POL_MRU = 3'd3;
  localparam logic [2:0] POL_LFU = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [4:0]        access_length;
    logic              is_store;
  } in_data_t;

  typedef struct packed {
    logic       all_hit;
    logic [2:0] blocks_touched;
    logic [2:0] miss_count;
    logic [2:0] compulsory_count;
    logic [2:0] conflict_count;
  } out_data_t;

  typedef struct packed {
    logic [2:0] replace_policy;
    logic [4:0] ways_in_use;
    logic [3:0] index_bits;
    logic [2:0] offset_bits;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [TICK_W-1:0] last_use;
    logic [UCNT_W-1:0] use_count;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic start;
    logic rd;
    logic cmp;
    logic mod;
    logic scan;
    logic wr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_mod;
    logic need_scan;
    logic mod_last;
    logic scan_last;
    logic blk_last;
    logic out_free;
  } sts_t;

  // fibonacci lfsr, taps 16 14 13 11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[LFSR_W-1:1]};
  endfunction

endpackage

FILE: rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// sacl_ctrl
// sequencer: clearing pass, per block read / compare / victim / write
// ----------------------------------------------------------------------------
module sacl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sacl_pkg::sts_t sts,
  output sacl_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_MOD   = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        priority if (sts.need_mod) state_nxt = S_MOD;
        else if (sts.need_scan)    state_nxt = S_SCAN;
        else                       state_nxt = S_WRITE;
      end
      S_MOD: begin
        cmd.mod = 1'b1;
        if (sts.mod_last) state_nxt = S_WRITE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = sts.blk_last ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

FILE: rtl/sacl_dp.sv
// ----------------------------------------------------------------------------
// sacl_dp
// datapath: block walk, set row storage, tag compare, victim choice, counts
// ----------------------------------------------------------------------------
module sacl_dp #(
  parameter int MAX_SETS         = 1024,
  parameter int MAX_WAYS         = 16,
  parameter int MAX_ACCESS_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sacl_pkg::cfg_t      cfg,
  input  sacl_pkg::in_data_t  in_data,
  input  sacl_pkg::cmd_t      cmd,
  output sacl_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output sacl_pkg::out_data_t out_data
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int NB_W   = $clog2(MAX_ACCESS_BYTES / 4 + 3);
  localparam int ROW_W  = WAY_W + MAX_WAYS * sacl_pkg::LINE_W;
  localparam int AW     = sacl_pkg::ADDR_W;
  localparam int LW     = sacl_pkg::LFSR_W;
  localparam int TW     = sacl_pkg::TICK_W;
  localparam int MC_W   = $clog2(LW);

  // effective configuration
  logic [WCNT_W-1:0] ways_eff;
  logic [3:0]        ib_eff;
  logic [2:0]        ob_eff;

  always_comb begin
    if (cfg.ways_in_use == 5'd0) ways_eff = WCNT_W'(1);
    else if (int'(cfg.ways_in_use) > MAX_WAYS) ways_eff = WCNT_W'(MAX_WAYS);
    else ways_eff = WCNT_W'(cfg.ways_in_use);
    ib_eff = (int'(cfg.index_bits) > IB_MAX) ? 4'(IB_MAX) : cfg.index_bits;
    if (cfg.offset_bits < 3'd2) ob_eff = 3'd2;
    else if (cfg.offset_bits > 3'd6) ob_eff = 3'd6;
    else ob_eff = cfg.offset_bits;
  end

  // access span
  logic [4:0]    len_c;
  logic [AW:0]   end_addr;
  logic [AW-1:0] first_blk;
  logic [AW:0]   span;

  always_comb begin
    if (in_data.access_length == 5'd0) len_c = 5'd1;
    else if (int'(in_data.access_length) > MAX_ACCESS_BYTES) len_c = 5'(MAX_ACCESS_BYTES);
    else len_c = in_data.access_length;
    end_addr  = {1'b0, in_data.byte_address} + (AW+1)'(len_c) - (AW+1)'(1);
    first_blk = in_data.byte_address >> ob_eff;
    span      = (end_addr >> ob_eff) - {1'b0, first_blk} + (AW+1)'(1);
  end

  logic [AW-1:0]   blk_r;
  logic [NB_W-1:0] nblk_r, k_r;
  logic [NB_W-1:0] miss_r, comp_r, conf_r;
  logic            store_r;
  logic [TW-1:0]   tick_r;
  logic [LW-1:0]   lfsr_r;
  logic [SET_W-1:0] clr_cnt_r;

  logic [AW-1:0]            bmask, set_full;
  logic [SET_W-1:0]         set_idx;
  logic [sacl_pkg::TAG_W-1:0] tag;

  assign bmask    = {AW{1'b1}} >> ob_eff;
  assign set_full = blk_r & ~({AW{1'b1}} << ib_eff);
  assign set_idx  = SET_W'(set_full);
  assign tag      = sacl_pkg::TAG_W'(blk_r >> ib_eff);

  // set row ram
  logic             ram_en, ram_we;
  logic [SET_W-1:0] ram_addr;
  logic [ROW_W-1:0] rd_data, row_new;

  assign ram_en   = cmd.clr | cmd.rd | cmd.wr;
  assign ram_we   = cmd.clr | cmd.wr;
  assign ram_addr = cmd.clr ? clr_cnt_r : set_idx;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.clr ? '0 : row_new),
    .rdata (rd_data)
  );

  sacl_pkg::line_t lines [MAX_WAYS];
  logic [WAY_W-1:0] rr_fld;
  logic [MAX_WAYS-1:0] hitv, invv;
  logic [WAY_W-1:0] hit_idx, inv_idx;

  always_comb begin
    rr_fld  = rd_data[ROW_W-1 -: WAY_W];
    hit_idx = '0;
    inv_idx = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      lines[w] = sacl_pkg::line_t'(rd_data[w*sacl_pkg::LINE_W +: sacl_pkg::LINE_W]);
      hitv[w]  = (w < int'(ways_eff)) && lines[w].valid && (lines[w].tag == tag);
      invv[w]  = (w < int'(ways_eff)) && !lines[w].valid;
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) hit_idx = WAY_W'(w);
      if (invv[w]) inv_idx = WAY_W'(w);
    end
  end

  logic any_hit, any_inv, full_miss;
  assign any_hit   = |hitv;
  assign any_inv   = |invv;
  assign full_miss = !any_hit && !any_inv;

  // victim selection state
  logic [WAY_W-1:0]  victim_r, scan_i_r;
  logic              hit_r, rr_upd_r;
  logic [TW-1:0]     best_r, cand;
  logic              better;
  logic [LW-1:0]     div_r;
  logic [WCNT_W-1:0] rem_r;
  logic [WCNT_W:0]   rem_tmp, rem_nxt;
  logic [MC_W-1:0]   mod_cnt_r;

  always_comb begin
    if (cfg.replace_policy == sacl_pkg::POL_LFU) begin
      cand = TW'(lines[scan_i_r].use_count);
    end else begin
      cand = lines[scan_i_r].last_use;
    end
    better  = (cfg.replace_policy == sacl_pkg::POL_MRU) ? (cand > best_r) : (cand < best_r);
    rem_tmp = {rem_r, div_r[LW-1]};
    rem_nxt = (rem_tmp >= (WCNT_W+1)'(ways_eff)) ? rem_tmp - (WCNT_W+1)'(ways_eff) : rem_tmp;
  end

  // updated row
  logic [WAY_W:0] rr_inc;
  always_comb begin
    sacl_pkg::line_t ln;
    rr_inc  = {1'b0, victim_r} + (WAY_W+1)'(1);
    row_new = rd_data;
    ln      = lines[victim_r];
    if (hit_r) begin
      ln.last_use = tick_r;
      if (!(&ln.use_count)) ln.use_count = ln.use_count + sacl_pkg::UCNT_W'(1);
      if (store_r) ln.dirty = 1'b1;
    end else begin
      ln.valid     = 1'b1;
      ln.dirty     = store_r;
      ln.tag       = tag;
      ln.last_use  = tick_r;
      ln.use_count = sacl_pkg::UCNT_W'(1);
    end
    row_new[victim_r*sacl_pkg::LINE_W +: sacl_pkg::LINE_W] = ln;
    if (rr_upd_r) begin
      row_new[ROW_W-1 -: WAY_W] = (int'(rr_inc) == int'(ways_eff)) ? '0 : WAY_W'(rr_inc);
    end
  end

  // control registers
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      lfsr_r      <= sacl_pkg::LFSR_SEED;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + SET_W'(1);
      if (cmd.rd) tick_r <= tick_r + TW'(1);
      if (cmd.cmp && full_miss && cfg.replace_policy == sacl_pkg::POL_RND) begin
        lfsr_r <= sacl_pkg::lfsr_next(lfsr_r);
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      blk_r   <= first_blk;
      nblk_r  <= NB_W'(span);
      k_r     <= '0;
      miss_r  <= '0;
      comp_r  <= '0;
      conf_r  <= '0;
      store_r <= in_data.is_store;
    end
    if (cmd.cmp) begin
      hit_r     <= any_hit;
      rr_upd_r  <= full_miss && cfg.replace_policy == sacl_pkg::POL_RR;
      scan_i_r  <= WAY_W'(1);
      rem_r     <= '0;
      mod_cnt_r <= '1;
      best_r    <= (cfg.replace_policy == sacl_pkg::POL_LFU) ? TW'(lines[0].use_count)
                                                            : lines[0].last_use;
      div_r     <= (cfg.replace_policy == sacl_pkg::POL_RND) ? sacl_pkg::lfsr_next(lfsr_r)
                                                            : LW'(rr_fld);
      if (any_hit) begin
        victim_r <= hit_idx;
      end else begin
        miss_r <= miss_r + NB_W'(1);
        if (any_inv) begin
          victim_r <= inv_idx;
          comp_r   <= comp_r + NB_W'(1);
        end else begin
          victim_r <= '0;
          conf_r   <= conf_r + NB_W'(1);
        end
      end
    end
    if (cmd.mod) begin
      rem_r     <= WCNT_W'(rem_nxt);
      div_r     <= div_r << 1;
      mod_cnt_r <= mod_cnt_r - MC_W'(1);
      victim_r  <= WAY_W'(rem_nxt);
    end
    if (cmd.scan) begin
      if (better) begin
        best_r   <= cand;
        victim_r <= scan_i_r;
      end
      scan_i_r <= scan_i_r + WAY_W'(1);
    end
    if (cmd.wr) begin
      blk_r <= (blk_r + AW'(1)) & bmask;
      k_r   <= k_r + NB_W'(1);
    end
    if (cmd.load_out) begin
      out_data.all_hit          <= (miss_r == '0);
      out_data.blocks_touched   <= 3'(nblk_r);
      out_data.miss_count       <= 3'(miss_r);
      out_data.compulsory_count <= 3'(comp_r);
      out_data.conflict_count   <= 3'(conf_r);
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.clr_last  = (int'(clr_cnt_r) == MAX_SETS - 1);
    sts.need_mod  = full_miss && (cfg.replace_policy == sacl_pkg::POL_RR ||
                                  cfg.replace_policy == sacl_pkg::POL_RND);
    sts.need_scan = full_miss && (ways_eff > WCNT_W'(1)) &&
                    (cfg.replace_policy == sacl_pkg::POL_LRU ||
                     cfg.replace_policy == sacl_pkg::POL_MRU ||
                     cfg.replace_policy == sacl_pkg::POL_LFU);
    sts.mod_last  = (mod_cnt_r == '0);
    sts.scan_last = (int'(scan_i_r) == int'(ways_eff) - 1);
    sts.blk_last  = (k_r == nblk_r - NB_W'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

FILE: rtl/set_assoc_cache_lookup_replace.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_replace
// set associative cache tag store with selectable replacement policy
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready / in_data): one memory access per
//   transaction, byte address, length in bytes and store flag
//   result channel (out_valid / out_ready / out_data): one summary per access,
//   all-hit flag and counts of blocks, misses, compulsory and conflict misses
//   config: apb-style port, registers at byte addresses 0, 4, 8, 12
// timing
//   an access is taken only while the sequencer is idle; each block it spans
//   goes through read, compare and write, plus a remainder unit pass under
//   round robin or random, or a victim scan of the ways in use under lru, mru
//   or lfu with more than one way, when every way in use is valid
// reset
//   after reset the set ram is cleared, one set row a cycle, over all MAX_SETS
//   set rows, and in_ready stays low during that pass
// stall
//   the result sits in an output register; the block holds in its final
//   state until the receiver takes the previous result
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_replace #(
  parameter int MAX_SETS         = 1024,
  parameter int MAX_WAYS         = 16,
  parameter int MAX_ACCESS_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // access transactions
  input  logic                in_valid,
  output logic                in_ready,
  input  sacl_pkg::in_data_t  in_data,
  // result transactions
  output logic                out_valid,
  input  logic                out_ready,
  output sacl_pkg::out_data_t out_data,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  sacl_pkg::cfg_t cfg_r;
  sacl_pkg::cmd_t cmd;
  sacl_pkg::sts_t sts;

  assign pready = 1'b1;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.replace_policy <= sacl_pkg::POL_RR;
      cfg_r.ways_in_use    <= 5'd1;
      cfg_r.index_bits     <= 4'd0;
      cfg_r.offset_bits    <= 3'd2;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        sacl_pkg::REG_POLICY: cfg_r.replace_policy <= pwdata[2:0];
        sacl_pkg::REG_WAYS:   cfg_r.ways_in_use    <= pwdata[4:0];
        sacl_pkg::REG_INDEX:  cfg_r.index_bits     <= pwdata[3:0];
        sacl_pkg::REG_OFFSET: cfg_r.offset_bits    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      sacl_pkg::REG_POLICY: prdata = {29'd0, cfg_r.replace_policy};
      sacl_pkg::REG_WAYS:   prdata = {27'd0, cfg_r.ways_in_use};
      sacl_pkg::REG_INDEX:  prdata = {28'd0, cfg_r.index_bits};
      sacl_pkg::REG_OFFSET: prdata = {29'd0, cfg_r.offset_bits};
      default:              prdata = '0;
    endcase
  end

  // sequencer
  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tag store, victim logic and counters
  sacl_dp #(
    .MAX_SETS         (MAX_SETS),
    .MAX_WAYS         (MAX_WAYS),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
